// ----- hw/rtl/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared sizes, register map and controller/datapath interface types for the
// lfu page replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

    localparam int FRAMES     = 8;
    localparam int PAGE_BITS  = 16;
    localparam int COUNT_BITS = 16;
    localparam int FAULT_BITS = 32;
    localparam int LIMIT_BITS = 4;
    localparam int FIDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FCNT_W     = $clog2(FRAMES + 1);

    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(3);

    localparam logic REG_FRAME_LIMIT = 1'b0;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic last;
        logic empty;
    } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lfu_page_replacement.sv -----
// sequence: an accepted reference scans k frames, where k is the match position plus
//   one on a hit, the resident count on a miss and zero when no page is resident;
//   the update then runs and the result beat is registered
// flow: no new reference is taken while busy; the scan is one-frame-per-cycle, and
//   busy drops in the cycle of the result beat
// reset: frame table empty, fault total zero, frame_limit 3; no clearing pass
// ----------------------------------------------------------------------------
// lfu_page_replacement
// Least-frequently-used page replacement unit with apb configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_page_replacement (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lfu_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [lfu_pkg::DATA_W-1:0]       pwdata,
    output logic      [lfu_pkg::DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [lfu_pkg::PAGE_BITS-1:0]    page,
    output logic                                  done,
    output logic                                  hit,
    output logic                                  evicted,
    output logic      [lfu_pkg::PAGE_BITS-1:0]    evicted_page,
    output logic      [lfu_pkg::COUNT_BITS-1:0]   evicted_count,
    output logic      [lfu_pkg::FAULT_BITS-1:0]   fault_total
);
    import lfu_pkg::*;

    logic [LIMIT_BITS-1:0] frame_limit;
    cmd_t                  cmd;
    status_t               status;

    lfu_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .frame_limit (frame_limit)
    );

    lfu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    lfu_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .page          (page),
        .frame_limit   (frame_limit),
        .status        (status),
        .hit           (hit),
        .evicted       (evicted),
        .evicted_page  (evicted_page),
        .evicted_count (evicted_count),
        .fault_total   (fault_total)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_cfg.sv -----
// ----------------------------------------------------------------------------
// lfu_cfg
// Configuration register block: holds frame_limit behind the apb port.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lfu_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [lfu_pkg::DATA_W-1:0]       pwdata,
    output logic      [lfu_pkg::DATA_W-1:0]       prdata,
    output logic                                  pready,
    output logic      [lfu_pkg::LIMIT_BITS-1:0]   frame_limit
);
    import lfu_pkg::*;

    logic [LIMIT_BITS-1:0] limit_reg;
    logic                  wr_en;
    logic                  sel_limit;

    assign sel_limit = (paddr[ADDR_W-1] == REG_FRAME_LIMIT);
    assign wr_en     = psel && penable && pwrite && sel_limit;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            limit_reg <= pwdata[LIMIT_BITS-1:0];
        end
    end

    assign prdata      = sel_limit ? DATA_W'(limit_reg) : '0;
    assign frame_limit = limit_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfu_ctrl
// Controller: sequences load, frame scan (skipped when no page is resident) and
// update for one reference and raises the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire lfu_pkg::status_t status,
    output lfu_pkg::cmd_t         cmd,
    output logic                  busy,
    output logic                  done
);
    import lfu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= status.empty ? ST_UPDATE : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (status.match || status.last)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cmd.load   = (state_reg == ST_IDLE) && start;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.update = (state_reg == ST_UPDATE);
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_dp.sv -----
// ----------------------------------------------------------------------------
// lfu_dp
// Datapath: frame table, one-frame-per-cycle match and minimum scan,
// eviction shift, append and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire lfu_pkg::cmd_t                    cmd,
    input  wire logic [lfu_pkg::PAGE_BITS-1:0]    page,
    input  wire logic [lfu_pkg::LIMIT_BITS-1:0]   frame_limit,
    output lfu_pkg::status_t                      status,
    output logic                                  hit,
    output logic                                  evicted,
    output logic      [lfu_pkg::PAGE_BITS-1:0]    evicted_page,
    output logic      [lfu_pkg::COUNT_BITS-1:0]   evicted_count,
    output logic      [lfu_pkg::FAULT_BITS-1:0]   fault_total
);
    import lfu_pkg::*;

    logic [PAGE_BITS-1:0]  pages_reg  [FRAMES];
    logic [COUNT_BITS-1:0] counts_reg [FRAMES];

    logic [FCNT_W-1:0]     used_reg;
    logic [FAULT_BITS-1:0] fault_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [FIDX_W-1:0]     idx_reg;
    logic                  found_reg;
    logic [FIDX_W-1:0]     where_reg;
    logic [FIDX_W-1:0]     victim_reg;
    logic [COUNT_BITS-1:0] min_reg;
    logic [PAGE_BITS-1:0]  vpage_reg;

    logic                  hit_reg;
    logic                  ev_reg;
    logic [PAGE_BITS-1:0]  ev_page_reg;
    logic [COUNT_BITS-1:0] ev_count_reg;

    logic [FCNT_W-1:0]     eff_limit;
    logic                  do_evict;
    logic [FCNT_W-1:0]     used_next;
    logic [FAULT_BITS-1:0] fault_next;
    logic                  take_min;

    // effective limit: zero acts as one, above build acts as full
    always_comb
    begin
        if (frame_limit == '0)
        begin
            eff_limit = FCNT_W'(1);
        end
        else if (FCNT_W'(frame_limit) > FCNT_W'(FRAMES) || frame_limit > LIMIT_BITS'(FRAMES))
        begin
            eff_limit = FCNT_W'(FRAMES);
        end
        else
        begin
            eff_limit = FCNT_W'(frame_limit);
        end
    end

    assign status.match = (pages_reg[idx_reg] == page_reg);
    assign status.last  = (FCNT_W'(idx_reg) + FCNT_W'(1) == used_reg);
    assign status.empty = (used_reg == '0);

    assign take_min   = (idx_reg == '0) || (counts_reg[idx_reg] < min_reg);
    assign do_evict   = !found_reg && (used_reg >= eff_limit) && (used_reg != '0);
    assign used_next  = used_reg - FCNT_W'(do_evict);
    assign fault_next = (fault_reg != '1) ? fault_reg + FAULT_BITS'(1) : fault_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            fault_reg <= '0;
        end
        else if (cmd.update && !found_reg)
        begin
            fault_reg <= fault_next;
            if (used_next < FCNT_W'(FRAMES))
            begin
                used_reg <= used_next + FCNT_W'(1);
            end
            else
            begin
                used_reg <= used_next;
            end
        end
    end

    // scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg  <= page;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            idx_reg <= idx_reg + FIDX_W'(1);
            if (status.match)
            begin
                found_reg <= 1'b1;
                where_reg <= idx_reg;
            end
            if (take_min)
            begin
                min_reg    <= counts_reg[idx_reg];
                victim_reg <= idx_reg;
                vpage_reg  <= pages_reg[idx_reg];
            end
        end
    end

    // frame table update: hit increment, or on a miss shift out the victim if any, then append
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (found_reg)
            begin
                if (counts_reg[where_reg] != '1)
                begin
                    counts_reg[where_reg] <= counts_reg[where_reg] + COUNT_BITS'(1);
                end
            end
            else
            begin
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (FCNT_W'(i) == used_next)
                    begin
                        pages_reg[i]  <= page_reg;
                        counts_reg[i] <= COUNT_BITS'(1);
                    end
                    else if (do_evict && FIDX_W'(i) >= victim_reg
                             && FCNT_W'(i + 1) < used_reg)
                    begin
                        pages_reg[i]  <= pages_reg[FIDX_W'((i + 1) % FRAMES)];
                        counts_reg[i] <= counts_reg[FIDX_W'((i + 1) % FRAMES)];
                    end
                end
            end
        end
    end

    // result beat
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hit_reg      <= found_reg;
            ev_reg       <= do_evict;
            ev_page_reg  <= do_evict ? vpage_reg : '0;
            ev_count_reg <= do_evict ? min_reg : '0;
        end
    end

    assign hit           = hit_reg;
    assign evicted       = ev_reg;
    assign evicted_page  = ev_page_reg;
    assign evicted_count = ev_count_reg;
    assign fault_total   = fault_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_checker.sv -----
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks for the lfu page replacement unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic                             busy,
    input  wire logic                             done,
    input  wire logic                             hit,
    input  wire logic                             evicted,
    input  wire logic [lfu_pkg::PAGE_BITS-1:0]    evicted_page,
    input  wire logic [lfu_pkg::COUNT_BITS-1:0]   evicted_count
);
    import lfu_pkg::*;

    // accepted reference keeps the unit busy
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("busy not raised after accept");

    // one beat per reference
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // unit is free again in the beat cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("busy during result beat");

    // a hit never evicts
    assert property (@(posedge clk) disable iff (!rst_n) done && hit |-> !evicted)
        else $error("eviction on hit");

    // no eviction means zero page and count
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !evicted |-> (evicted_page == '0) && (evicted_count == '0))
        else $error("eviction fields nonzero without eviction");

endmodule

bind lfu_page_replacement lfu_checker u_lfu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .evicted       (evicted),
    .evicted_page  (evicted_page),
    .evicted_count (evicted_count)
);

`default_nettype wire

// ----- dv/lfu_page_replacement_tb.sv -----
// ----------------------------------------------------------------------------
// lfu_page_replacement_tb
// Self-checking bench for the lfu page replacement unit. A directed table
// covers a long hit run, tie breaking, frame limits of zero and above the
// build size, and a lowered limit. Random phases then sweep the frame limit
// and the sender idle rate. Every result beat is compared field by field with
// the typed row outcome, or else a cycle-free predictor of the frame table.
// ----------------------------------------------------------------------------
module lfu_page_replacement_tb;

    import lfu_pkg::*;

    localparam int                LIMIT_CYCLES = 200_000;
    localparam int                NUM_PHASES   = 8;
    localparam int                PHASE_ITEMS  = 100;
    localparam logic [ADDR_W-1:0] LIMIT_ADDR   = ADDR_W'(4 * int'(REG_FRAME_LIMIT));

    typedef struct packed {
        logic                  hit;
        logic                  evicted;
        logic [PAGE_BITS-1:0]  ev_page;
        logic [COUNT_BITS-1:0] ev_count;
        logic [FAULT_BITS-1:0] fault_total;
    } outcome_t;

    typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] value;
        int          reps;
        bit          typed;
        outcome_t    want;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    logic [PAGE_BITS-1:0]  page;
    logic                  done;
    logic                  hit;
    logic                  evicted;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [COUNT_BITS-1:0] evicted_count;
    logic [FAULT_BITS-1:0] fault_total;

    // predictor state
    logic [PAGE_BITS-1:0]  frame_page [FRAMES];
    logic [COUNT_BITS-1:0] frame_uses [FRAMES];
    int                    frames_held;
    logic [FAULT_BITS-1:0] fault_sum;
    logic [LIMIT_BITS-1:0] limit_reg;

    outcome_t pending_results [$];
    outcome_t head;
    int       mismatches;
    int       cycle_count;

    // long hit run first, while only one page is resident
    row_t directed_rows [0:24] = '{
        '{ROW_REF, 16'h0000, 1,     1'b1, '{1'b0, 1'b0, 16'h0000, 16'h0000, 32'd1}},
        '{ROW_REF, 16'h0000, 40,    1'b1, '{1'b1, 1'b0, 16'h0000, 16'h0000, 32'd1}},
        '{ROW_CFG, 16'd1,    1,     1'b0, '0},
        '{ROW_REF, 16'hFFFF, 1,     1'b1, '{1'b0, 1'b1, 16'h0000, 16'h0029, 32'd2}},
        '{ROW_CFG, 16'd3,    1,     1'b0, '0},
        '{ROW_REF, 16'hFFFF, 1,     1'b1, '{1'b1, 1'b0, 16'h0000, 16'h0000, 32'd2}},
        '{ROW_REF, 16'h1234, 1,     1'b1, '{1'b0, 1'b0, 16'h0000, 16'h0000, 32'd3}},
        '{ROW_REF, 16'h0000, 1,     1'b1, '{1'b0, 1'b0, 16'h0000, 16'h0000, 32'd4}},
        '{ROW_REF, 16'hABCD, 1,     1'b1, '{1'b0, 1'b1, 16'h1234, 16'h0001, 32'd5}},
        '{ROW_REF, 16'h0000, 1,     1'b1, '{1'b1, 1'b0, 16'h0000, 16'h0000, 32'd5}},
        '{ROW_REF, 16'h5555, 1,     1'b1, '{1'b0, 1'b1, 16'hABCD, 16'h0001, 32'd6}},
        '{ROW_CFG, 16'd0,    1,     1'b0, '0},
        '{ROW_REF, 16'hAAAA, 1,     1'b1, '{1'b0, 1'b1, 16'h5555, 16'h0001, 32'd7}},
        '{ROW_REF, 16'h0000, 1,     1'b1, '{1'b1, 1'b0, 16'h0000, 16'h0000, 32'd7}},
        '{ROW_REF, 16'h7777, 1,     1'b1, '{1'b0, 1'b1, 16'hAAAA, 16'h0001, 32'd8}},
        '{ROW_CFG, 16'd15,   1,     1'b0, '0},
        '{ROW_REF, 16'h0001, 1,     1'b1, '{1'b0, 1'b0, 16'h0000, 16'h0000, 32'd9}},
        '{ROW_REF, 16'h0002, 1,     1'b1, '{1'b0, 1'b0, 16'h0000, 16'h0000, 32'd10}},
        '{ROW_REF, 16'h0004, 1,     1'b1, '{1'b0, 1'b0, 16'h0000, 16'h0000, 32'd11}},
        '{ROW_REF, 16'h0008, 1,     1'b1, '{1'b0, 1'b0, 16'h0000, 16'h0000, 32'd12}},
        '{ROW_REF, 16'h8000, 1,     1'b1, '{1'b0, 1'b0, 16'h0000, 16'h0000, 32'd13}},
        '{ROW_REF, 16'h4000, 1,     1'b1, '{1'b0, 1'b1, 16'h7777, 16'h0001, 32'd14}},
        '{ROW_CFG, 16'd8,    1,     1'b0, '0},
        '{ROW_REF, 16'h0001, 1,     1'b0, '0},
        '{ROW_REF, 16'h1234, 1,     1'b0, '0}
    };

    int                    phase_limits [NUM_PHASES] = '{2, 8, 0, 15, 1, 5, 3, 9};
    int                    phase_idle   [NUM_PHASES] = '{0, 51, 7, 51, 0, 7, 51, 0};
    logic [PAGE_BITS-1:0]  page_pool [16];

    lfu_page_replacement u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .page          (page),
        .done          (done),
        .hit           (hit),
        .evicted       (evicted),
        .evicted_page  (evicted_page),
        .evicted_count (evicted_count),
        .fault_total   (fault_total)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic outcome_t predict_reference(input logic [PAGE_BITS-1:0] pg);
        outcome_t r;
        int       slot;
        int       victim;
        int       cap;
        int       i;
        r    = '0;
        slot = -1;
        cap  = (limit_reg == 0) ? 1 : ((int'(limit_reg) > FRAMES) ? FRAMES : int'(limit_reg));
        for (i = 0; i < frames_held; i++)
        begin
            if (slot < 0 && frame_page[i] == pg)
                slot = i;
        end
        if (slot >= 0)
        begin
            r.hit = 1'b1;
            if (frame_uses[slot] != '1)
                frame_uses[slot] = frame_uses[slot] + 1'b1;
        end
        else
        begin
            if (fault_sum != '1)
                fault_sum = fault_sum + 1'b1;
            if (frames_held >= cap && frames_held > 0)
            begin
                victim = 0;
                for (i = 1; i < frames_held; i++)
                begin
                    if (frame_uses[i] < frame_uses[victim])
                        victim = i;
                end
                r.evicted  = 1'b1;
                r.ev_page  = frame_page[victim];
                r.ev_count = frame_uses[victim];
                for (i = victim; i + 1 < frames_held; i++)
                begin
                    frame_page[i] = frame_page[i + 1];
                    frame_uses[i] = frame_uses[i + 1];
                end
                frames_held--;
            end
            if (frames_held < FRAMES)
            begin
                frame_page[frames_held] = pg;
                frame_uses[frames_held] = 1;
                frames_held++;
            end
        end
        r.fault_total = fault_sum;
        return r;
    endfunction

    // sender pause: start low until every pending beat has come back
    task automatic wait_for_results();
        start <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
    endtask

    task automatic set_frame_limit(input logic [LIMIT_BITS-1:0] v);
        wait_for_results();
        repeat (FRAMES + 2) @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= LIMIT_ADDR;
        pwdata  <= DATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_reg = v;
    endtask

    // called and returns at a falling edge; start stays high for back-to-back beats
    task automatic send_ref(input logic [PAGE_BITS-1:0] pg, input int idle_pct,
                            input bit typed, input outcome_t want);
        outcome_t predicted;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        page  <= pg;
        do @(posedge clk); while (busy);
        predicted = predict_reference(pg);
        if (typed)
            predicted = want;
        pending_results = {pending_results, predicted};
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing pending");
                mismatches++;
            end
            else
            begin
                head = pending_results.pop_front();
                if (hit !== head.hit)
                begin
                    $error("hit: expected %0d, got %0d", head.hit, hit);
                    mismatches++;
                end
                if (evicted !== head.evicted)
                begin
                    $error("evicted: expected %0d, got %0d", head.evicted, evicted);
                    mismatches++;
                end
                if (evicted_page !== head.ev_page)
                begin
                    $error("evicted_page: expected %0h, got %0h", head.ev_page, evicted_page);
                    mismatches++;
                end
                if (evicted_count !== head.ev_count)
                begin
                    $error("evicted_count: expected %0d, got %0d", head.ev_count,
                           evicted_count);
                    mismatches++;
                end
                if (fault_total !== head.fault_total)
                begin
                    $error("fault_total: expected %0d, got %0d", head.fault_total,
                           fault_total);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("lfu_page_replacement_tb: errors");
            $finish;
        end
    end

    initial
    begin
        int r;
        int k;
        int ph;
        int n;
        int pool_n;
        logic [PAGE_BITS-1:0] pg;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        start       = 1'b0;
        page        = '0;
        mismatches  = 0;
        cycle_count = 0;
        frames_held = 0;
        fault_sum   = '0;
        limit_reg   = LIMIT_RESET;
        for (k = 0; k < FRAMES; k++)
        begin
            frame_page[k] = '0;
            frame_uses[k] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (r = 0; r < $size(directed_rows); r++)
        begin
            if (directed_rows[r].kind == ROW_CFG)
                set_frame_limit(directed_rows[r].value[LIMIT_BITS-1:0]);
            else
                for (k = 0; k < directed_rows[r].reps; k++)
                    send_ref(directed_rows[r].value, 0, directed_rows[r].typed,
                             directed_rows[r].want);
        end

        // random phases: mostly pages from a small pool so hits and evictions mix
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_frame_limit(LIMIT_BITS'(phase_limits[ph]));
            pool_n = $urandom_range(2, 16);
            for (k = 0; k < pool_n; k++)
                page_pool[k] = PAGE_BITS'($urandom_range(0, 65535));
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 3)
                    wait_for_results();
                if ($urandom_range(99) < 80)
                    pg = page_pool[$urandom_range(0, pool_n - 1)];
                else
                    pg = PAGE_BITS'($urandom());
                send_ref(pg, phase_idle[ph], 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (FRAMES + 2) @(negedge clk);
        if (mismatches == 0)
            $display("lfu_page_replacement_tb: clean");
        else
            $display("lfu_page_replacement_tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_cfg.sv
hw/rtl/lfu_ctrl.sv
hw/rtl/lfu_dp.sv
hw/rtl/lfu_page_replacement.sv
hw/rtl/lfu_checker.sv
dv/lfu_page_replacement_tb.sv
